FILE: hdl/dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants and types for the double-ended queue: opcodes, the
// default depth, the empty marker value and the sequencer state encoding.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int unsigned DQ_DEPTH = 1024;

    localparam logic [2:0] OP_QUERY      = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_POP_BACK   = 3'd4;

    localparam logic signed [31:0] NEG_ONE = -32'sd1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_FILL = 3'b100
    } dq_state_t;

endpackage
`default_nettype wire

FILE: hdl/dq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ram
// Single-port entry store with registered read data.
// ----------------------------------------------------------------------------
module dq_ram
    import dq_pkg::*;
#(
    parameter int unsigned DEPTH = DQ_DEPTH,
    parameter int unsigned IDX_W = $clog2(DEPTH)
)
(
    input  wire logic                    clk,
    input  wire logic                    wr_en,
    input  wire logic                    rd_en,
    input  wire logic [IDX_W-1:0]        addr,
    input  wire logic signed [31:0]      wdata,
    output logic signed [31:0]           rdata
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: hdl/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of signed 32-bit values held in a ring buffer memory.
// ----------------------------------------------------------------------------
// Issue an item by raising start while busy is low; it is taken at that
// clock edge. Each item (query, push front, push back, pop front, pop back)
// yields exactly one result, shown on the result ports for one cycle with
// done high, after the update state (S_EXEC), the refresh state (S_FILL) and
// the result registers. The receiver cannot stall the block, so capture the
// result whenever done is high. A new item may be taken in the refresh state
// of the last one: the update state changes the indices and writes the memory
// (push) or starts a read of the new end entry (pop); the refresh state takes
// the read data of the single memory port to refresh the cached front and
// back values. Busy is high only in the update state. Reset does not clear
// the memory; only held entries are read, so the queue is usable at once.
// A push into a full queue is dropped and flagged; a pop of an empty queue
// returns -1 and is flagged. Front and back read -1 while the queue is empty.
// ----------------------------------------------------------------------------
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int unsigned DEPTH = DQ_DEPTH,
    parameter int unsigned IDX_W = $clog2(DEPTH),
    parameter int unsigned CNT_W = $clog2(DEPTH + 1)
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [2:0]              opcode,
    input  wire logic signed [31:0]      item_value,
    output logic                         done,
    output logic signed [31:0]           popped_value,
    output logic                         pop_was_empty,
    output logic signed [31:0]           front_value,
    output logic signed [31:0]           back_value,
    output logic [CNT_W-1:0]             entry_count,
    output logic                         is_empty,
    output logic                         push_dropped
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // Sequencer and queue bookkeeping
    dq_state_t          state_reg, state_next;
    logic [IDX_W-1:0]   front_idx_reg, front_idx_next;
    logic [IDX_W-1:0]   back_idx_reg, back_idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // Latched item
    logic [2:0]         op_reg, op_next;
    logic signed [31:0] val_reg, val_next;

    // Cached end values, valid while the queue holds entries
    logic signed [31:0] front_val_reg, front_val_next;
    logic signed [31:0] back_val_reg, back_val_next;

    // Partial result carried from the update cycle to the refresh cycle
    logic signed [31:0] pop_val_reg, pop_val_next;
    logic               pop_empty_reg, pop_empty_next;
    logic               drop_reg, drop_next;
    logic               rd_front_reg, rd_front_next;
    logic               rd_back_reg, rd_back_next;

    // Result registers
    logic               done_reg, done_next;
    logic signed [31:0] res_popped_reg, res_popped_next;
    logic               res_pop_empty_reg, res_pop_empty_next;
    logic signed [31:0] res_front_reg, res_front_next;
    logic signed [31:0] res_back_reg, res_back_next;
    logic [CNT_W-1:0]   res_count_reg, res_count_next;
    logic               res_empty_reg, res_empty_next;
    logic               res_drop_reg, res_drop_next;

    // Memory port
    logic               mem_wr_en;
    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_addr;
    logic signed [31:0] mem_wdata;
    logic signed [31:0] mem_rdata;

    logic               accept;
    logic               q_empty;
    logic               q_full;
    logic               q_multi;
    logic [IDX_W-1:0]   front_prev;
    logic [IDX_W-1:0]   front_succ;
    logic [IDX_W-1:0]   back_prev;
    logic [IDX_W-1:0]   back_succ;

    dq_ram #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .wr_en (mem_wr_en),
        .rd_en (mem_rd_en),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign busy   = (state_reg == S_EXEC);
    assign accept = start && !busy;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == FULL_CNT);
    assign q_multi = (count_reg > CNT_W'(1));

    // Ring neighbours, wrapping at the last slot
    assign front_prev = (front_idx_reg == '0) ? LAST_IDX : front_idx_reg - IDX_W'(1);
    assign front_succ = (front_idx_reg == LAST_IDX) ? '0 : front_idx_reg + IDX_W'(1);
    assign back_prev  = (back_idx_reg == '0) ? LAST_IDX : back_idx_reg - IDX_W'(1);
    assign back_succ  = (back_idx_reg == LAST_IDX) ? '0 : back_idx_reg + IDX_W'(1);

    always_comb
    begin
        state_next         = state_reg;
        front_idx_next     = front_idx_reg;
        back_idx_next      = back_idx_reg;
        count_next         = count_reg;
        op_next            = op_reg;
        val_next           = val_reg;
        front_val_next     = front_val_reg;
        back_val_next      = back_val_reg;
        pop_val_next       = pop_val_reg;
        pop_empty_next     = pop_empty_reg;
        drop_next          = drop_reg;
        rd_front_next      = rd_front_reg;
        rd_back_next       = rd_back_reg;
        done_next          = 1'b0;
        res_popped_next    = res_popped_reg;
        res_pop_empty_next = res_pop_empty_reg;
        res_front_next     = res_front_reg;
        res_back_next      = res_back_reg;
        res_count_next     = res_count_reg;
        res_empty_next     = res_empty_reg;
        res_drop_next      = res_drop_reg;
        mem_wr_en          = 1'b0;
        mem_rd_en          = 1'b0;
        mem_addr           = front_idx_reg;
        mem_wdata          = val_reg;

        // Latch a new item; only possible outside the update cycle
        if (accept)
        begin
            op_next  = opcode;
            val_next = item_value;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                // Update indices and count; write on push, start refresh read on pop
                pop_val_next   = NEG_ONE;
                pop_empty_next = 1'b0;
                drop_next      = 1'b0;
                rd_front_next  = 1'b0;
                rd_back_next   = 1'b0;
                state_next     = S_FILL;

                if ((op_reg == OP_PUSH_FRONT) || (op_reg == OP_PUSH_BACK))
                begin
                    if (q_full)
                    begin
                        drop_next = 1'b1;
                    end
                    else if (q_empty)
                    begin
                        // First entry lands at the front slot; both ends meet there
                        mem_wr_en      = 1'b1;
                        mem_addr       = front_idx_reg;
                        back_idx_next  = front_idx_reg;
                        count_next     = CNT_W'(1);
                        front_val_next = val_reg;
                        back_val_next  = val_reg;
                    end
                    else if (op_reg == OP_PUSH_FRONT)
                    begin
                        mem_wr_en      = 1'b1;
                        mem_addr       = front_prev;
                        front_idx_next = front_prev;
                        count_next     = count_reg + CNT_W'(1);
                        front_val_next = val_reg;
                    end
                    else
                    begin
                        mem_wr_en     = 1'b1;
                        mem_addr      = back_succ;
                        back_idx_next = back_succ;
                        count_next    = count_reg + CNT_W'(1);
                        back_val_next = val_reg;
                    end
                end
                else if ((op_reg == OP_POP_FRONT) || (op_reg == OP_POP_BACK))
                begin
                    if (q_empty)
                    begin
                        pop_empty_next = 1'b1;
                    end
                    else if (op_reg == OP_POP_FRONT)
                    begin
                        pop_val_next = front_val_reg;
                        count_next   = count_reg - CNT_W'(1);
                        // Last entry leaves the indices where they stand
                        if (q_multi)
                        begin
                            front_idx_next = front_succ;
                            mem_rd_en      = 1'b1;
                            mem_addr       = front_succ;
                            rd_front_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        pop_val_next = back_val_reg;
                        count_next   = count_reg - CNT_W'(1);
                        if (q_multi)
                        begin
                            back_idx_next = back_prev;
                            mem_rd_en     = 1'b1;
                            mem_addr      = back_prev;
                            rd_back_next  = 1'b1;
                        end
                    end
                end
            end

            S_FILL:
            begin
                // Refresh the cached end from the read data and publish the result
                if (rd_front_reg)
                begin
                    front_val_next = mem_rdata;
                end
                if (rd_back_reg)
                begin
                    back_val_next = mem_rdata;
                end

                done_next          = 1'b1;
                res_popped_next    = pop_val_reg;
                res_pop_empty_next = pop_empty_reg;
                res_front_next     = q_empty ? NEG_ONE : front_val_next;
                res_back_next      = q_empty ? NEG_ONE : back_val_next;
                res_count_next     = count_reg;
                res_empty_next     = q_empty;
                res_drop_next      = drop_reg;

                state_next = accept ? S_EXEC : S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_idx_reg <= '0;
            back_idx_reg  <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_idx_reg <= front_idx_next;
            back_idx_reg  <= back_idx_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        val_reg           <= val_next;
        front_val_reg     <= front_val_next;
        back_val_reg      <= back_val_next;
        pop_val_reg       <= pop_val_next;
        pop_empty_reg     <= pop_empty_next;
        drop_reg          <= drop_next;
        rd_front_reg      <= rd_front_next;
        rd_back_reg       <= rd_back_next;
        res_popped_reg    <= res_popped_next;
        res_pop_empty_reg <= res_pop_empty_next;
        res_front_reg     <= res_front_next;
        res_back_reg      <= res_back_next;
        res_count_reg     <= res_count_next;
        res_empty_reg     <= res_empty_next;
        res_drop_reg      <= res_drop_next;
    end

    assign done          = done_reg;
    assign popped_value  = res_popped_reg;
    assign pop_was_empty = res_pop_empty_reg;
    assign front_value   = res_front_reg;
    assign back_value    = res_back_reg;
    assign entry_count   = res_count_reg;
    assign is_empty      = res_empty_reg;
    assign push_dropped  = res_drop_reg;

endmodule
`default_nettype wire

FILE: hdl/dq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module dq_checker
    import dq_pkg::*;
#(
    parameter int unsigned DEPTH = DQ_DEPTH,
    parameter int unsigned CNT_W = $clog2(DEPTH + 1)
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic                    busy,
    input  wire logic                    done,
    input  wire logic signed [31:0]      popped_value,
    input  wire logic                    pop_was_empty,
    input  wire logic signed [31:0]      front_value,
    input  wire logic signed [31:0]      back_value,
    input  wire logic [CNT_W-1:0]        entry_count,
    input  wire logic                    is_empty,
    input  wire logic                    push_dropped
);

    // Every taken item is followed by its done strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result strobe missing three cycles after an item");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_empty) |-> ((front_value == NEG_ONE) && (back_value == NEG_ONE)))
        else $error("ends of an empty queue not -1");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pop_was_empty) |-> ((popped_value == NEG_ONE) && is_empty && !push_dropped))
        else $error("pop of empty queue reported wrongly");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && push_dropped) |-> (entry_count == CNT_W'(DEPTH)))
        else $error("push dropped while queue not full");

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
`default_nettype wire
